@@ design/gru_pkg.sv @@
// gru_pkg: shared constants, fixed-point helpers and activation table generation
// for the gru element-wise gate pipeline. No dependencies.
package gru_pkg;

   localparam int DEF_ACT_TABLE_DEPTH = 1024;
   localparam int PIPE_LATENCY        = 8;
   localparam int FX_W                = 16;
   localparam logic signed [FX_W-1:0] FX_ONE = 16'sd2048;

   typedef enum logic {
      OP_FWD = 1'b0,
      OP_BWD = 1'b1
   } op_type;

   localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
   localparam logic [63:0] Q30_MASK  = Q30_ONE - 64'd1;
   localparam logic [63:0] Q30_INV_E = 64'd395007542;

   // saturate a wide signed value to 16 bits
   function automatic logic signed [FX_W-1:0] sat18(input logic signed [17:0] v);
      logic signed [FX_W-1:0] res;
      begin
         if (v > 18'sd32767) begin
            res = 16'sh7fff;
         end else if (v < -18'sd32768) begin
            res = 16'sh8000;
         end else begin
            res = v[FX_W-1:0];
         end
         return res;
      end
   endfunction

   // product scaling: add half lsb, floor shift, saturate
   function automatic logic signed [FX_W-1:0] fx_round(input logic signed [31:0] p);
      logic signed [32:0] s;
      logic signed [21:0] q;
      begin
         s = 33'(p) + 33'sd1024;
         q = 22'(s >>> 11);
         if (q > 22'sd32767) begin
            return 16'sh7fff;
         end else if (q < -22'sd32768) begin
            return 16'sh8000;
         end
         return q[FX_W-1:0];
      end
   endfunction

   // shift-subtract divider, elaboration use only
   function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      begin
         rem = '0;
         quo = '0;
         for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
               rem    = rem - {1'b0, den};
               quo[b] = 1'b1;
            end
         end
         return quo;
      end
   endfunction

   function automatic logic [63:0] exp_neg_q30(input logic [63:0] a);
      logic [63:0] n;
      logic [63:0] f;
      logic signed [63:0] sum;
      logic [63:0] term;
      logic [63:0] r;
      begin
         n    = a >> 30;
         f    = a & Q30_MASK;
         sum  = signed'(Q30_ONE);
         term = Q30_ONE;
         for (int j = 1; j <= 20; j++) begin
            term = udiv((term * f) >> 30, 64'(j));
            if (j % 2 == 1) begin
               sum = sum - signed'(term);
            end else begin
               sum = sum + signed'(term);
            end
         end
         if (sum < 0) begin
            sum = '0;
         end
         r = unsigned'(sum);
         for (int j = 0; j < 64; j++) begin
            if (64'(j) < n) begin
               r = (r * Q30_INV_E + (Q30_ONE >> 1)) >> 30;
            end
         end
         return r;
      end
   endfunction

   // table entry at the midpoint of bin idx
   function automatic logic signed [FX_W-1:0] act_value(input int idx, input int depth,
                                                        input bit is_tanh);
      longint k;
      logic [63:0] mag;
      logic [63:0] a;
      logic [63:0] e;
      logic [63:0] d;
      logic [63:0] t;
      begin
         k   = 2 * longint'(idx) + 1 - longint'(depth);
         mag = (k < 0) ? 64'(-k) : 64'(k);
         if (is_tanh) begin
            a = udiv((mag << 34) + 64'(depth / 2), 64'(depth));
         end else begin
            a = udiv((mag << 33) + 64'(depth / 2), 64'(depth));
         end
         e = exp_neg_q30(a);
         d = Q30_ONE + e;
         if (is_tanh) begin
            t = udiv(((Q30_ONE - e) << 11) + (d >> 1), d);
            return (k < 0) ? -t[FX_W-1:0] : t[FX_W-1:0];
         end
         if (k < 0) begin
            t = udiv((e << 11) + (d >> 1), d);
         end else begin
            t = udiv((64'd1 << 41) + (d >> 1), d);
         end
         return t[FX_W-1:0];
      end
   endfunction

endpackage

@@ design/gru_act_rom.sv @@
// gru_act_rom: clamped index and registered lookup into a sigmoid or tanh table.
// Depends on gru_pkg for the table generator.
module gru_act_rom #(
   parameter int DEPTH   = gru_pkg::DEF_ACT_TABLE_DEPTH,
   parameter bit IS_TANH = 1'b0
) (
   input  logic                                 clock,
   input  logic signed [16:0]                   arg,
   output logic signed [gru_pkg::FX_W-1:0]      value_ff
);
   import gru_pkg::*;

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int PROD_W = 15 + $clog2(DEPTH + 1);

   logic signed [FX_W-1:0] rom [DEPTH];
   logic signed [16:0]     clamped;
   logic [14:0]            offset;
   logic [PROD_W-1:0]      scaled;
   logic [IDX_W-1:0]       idx;

   for (genvar g = 0; g < DEPTH; g++) begin : g_rom
      localparam logic signed [FX_W-1:0] ENTRY = act_value(g, DEPTH, IS_TANH);
      assign rom[g] = ENTRY;
   end

   always_comb begin
      if (arg < -17'sd16384) begin
         clamped = -17'sd16384;
      end else if (arg > 17'sd16383) begin
         clamped = 17'sd16383;
      end else begin
         clamped = arg;
      end
      offset = 15'(clamped + 17'sd16384);
      scaled = PROD_W'(offset) * PROD_W'(DEPTH);
      idx    = IDX_W'(scaled >> 15);
   end

   always_ff @(posedge clock) begin
      value_ff <= rom[idx];
   end
endmodule

@@ design/gru_gate_fwd_bwd.sv @@
// gru_gate_fwd_bwd: top level of the gru element-wise gate pipeline.
// Depends on gru_pkg and gru_act_rom.
//
// usage
//   one hidden element per transfer on the req_ side: start high while busy
//   is low moves req_opcode and the eight q4.11 operands into the pipeline
//   forward (opcode 0) returns hidden_new, backward (opcode 1) returns the
//   five gradient increments; unused result fields read zero
//   every transfer gives exactly one result, shown for one cycle with
//   rsp_valid high; the receiver has no way to stall it
// timing
//   a transfer passes in order through the eight-stage pipeline (operand
//   register, sigmoid lookups, r*hh_cand, tanh lookup, three product levels
//   for the gradients, last products with the output register); throughput
//   is one element per cycle while busy is low
// reset
//   synchronous, active high; clears all valid bits; busy is high during
//   reset and the cycle after, low otherwise
module gru_gate_fwd_bwd #(
   parameter int ACT_TABLE_DEPTH = gru_pkg::DEF_ACT_TABLE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_opcode,
   input  logic signed [gru_pkg::FX_W-1:0]     req_ih_reset,
   input  logic signed [gru_pkg::FX_W-1:0]     req_ih_update,
   input  logic signed [gru_pkg::FX_W-1:0]     req_ih_cand,
   input  logic signed [gru_pkg::FX_W-1:0]     req_hh_reset,
   input  logic signed [gru_pkg::FX_W-1:0]     req_hh_update,
   input  logic signed [gru_pkg::FX_W-1:0]     req_hh_cand,
   input  logic signed [gru_pkg::FX_W-1:0]     req_hidden_old,
   input  logic signed [gru_pkg::FX_W-1:0]     req_grad_in,
   output logic                                rsp_valid,
   output logic signed [gru_pkg::FX_W-1:0]     rsp_hidden_new,
   output logic signed [gru_pkg::FX_W-1:0]     rsp_grad_reset,
   output logic signed [gru_pkg::FX_W-1:0]     rsp_grad_update,
   output logic signed [gru_pkg::FX_W-1:0]     rsp_grad_ih_cand,
   output logic signed [gru_pkg::FX_W-1:0]     rsp_grad_hh_cand,
   output logic signed [gru_pkg::FX_W-1:0]     rsp_grad_hidden
);
   import gru_pkg::*;

   typedef logic signed [FX_W-1:0] fx_type;

   // valid bit per stage
   logic [PIPE_LATENCY-1:0] valid_ff, valid_in;
   logic                    busy_ff;

   // stage 1: registered operands
   op_type s1_op_ff;
   fx_type s1_ihr_ff, s1_ihu_ff, s1_ihc_ff, s1_hhr_ff, s1_hhu_ff, s1_hhc_ff;
   fx_type s1_h_ff, s1_d_ff;
   logic signed [16:0] sum_r, sum_z;

   // stage 2: gates r and z from the tables
   fx_type r2, z2;
   op_type s2_op_ff;
   fx_type s2_ihc_ff, s2_hhc_ff, s2_h_ff, s2_d_ff;

   // stage 3: raw r*hh_cand
   logic signed [31:0] s3_rh_ff;
   op_type s3_op_ff;
   fx_type s3_r_ff, s3_z_ff, s3_ihc_ff, s3_hhc_ff, s3_h_ff, s3_d_ff;
   logic signed [16:0] cand_arg;

   // stage 4: candidate n from the table
   fx_type n4;
   op_type s4_op_ff;
   fx_type s4_r_ff, s4_z_ff, s4_hhc_ff, s4_h_ff, s4_d_ff;
   fx_type omz4, omr4;

   // stage 5: first product level
   op_type s5_op_ff;
   fx_type s5_zh_ff, s5_omzn_ff, s5_c_ff, s5_nn_ff, s5_zd_ff, s5_rr_ff, s5_hmn_ff;
   fx_type s5_r_ff, s5_z_ff, s5_hhc_ff;

   // stage 6: second product level
   op_type s6_op_ff;
   fx_type s6_hnew_ff, s6_dn_ff, s6_c_ff, s6_zhn_ff, s6_rrh_ff, s6_zd_ff, s6_r_ff;

   // stage 7: candidate gradient and update gradient
   op_type s7_op_ff;
   fx_type s7_gihc_ff, s7_gupd_ff, s7_rrh_ff, s7_r_ff, s7_hnew_ff, s7_zd_ff;

   // stage 8: output register
   fx_type out_hnew_ff, out_greset_ff, out_gupd_ff, out_gihc_ff, out_ghhc_ff, out_ghid_ff;

   assign busy     = busy_ff;
   assign valid_in = {valid_ff[PIPE_LATENCY-2:0], start & ~busy_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         busy_ff  <= 1'b1;
      end else begin
         valid_ff <= valid_in;
         busy_ff  <= 1'b0;
      end
   end

   // stage 1
   always_ff @(posedge clock) begin
      s1_op_ff  <= op_type'(req_opcode);
      s1_ihr_ff <= req_ih_reset;
      s1_ihu_ff <= req_ih_update;
      s1_ihc_ff <= req_ih_cand;
      s1_hhr_ff <= req_hh_reset;
      s1_hhu_ff <= req_hh_update;
      s1_hhc_ff <= req_hh_cand;
      s1_h_ff   <= req_hidden_old;
      s1_d_ff   <= req_grad_in;
   end

   assign sum_r = 17'(s1_ihr_ff) + 17'(s1_hhr_ff);
   assign sum_z = 17'(s1_ihu_ff) + 17'(s1_hhu_ff);

   gru_act_rom #(.DEPTH(ACT_TABLE_DEPTH), .IS_TANH(1'b0)) u_rom_reset (
      .clock(clock), .arg(sum_r), .value_ff(r2)
   );
   gru_act_rom #(.DEPTH(ACT_TABLE_DEPTH), .IS_TANH(1'b0)) u_rom_update (
      .clock(clock), .arg(sum_z), .value_ff(z2)
   );

   always_ff @(posedge clock) begin
      s2_op_ff  <= s1_op_ff;
      s2_ihc_ff <= s1_ihc_ff;
      s2_hhc_ff <= s1_hhc_ff;
      s2_h_ff   <= s1_h_ff;
      s2_d_ff   <= s1_d_ff;
   end

   // stage 3: reset gate applied to the hidden-side candidate
   always_ff @(posedge clock) begin
      s3_rh_ff  <= 32'(r2) * 32'(s2_hhc_ff);
      s3_op_ff  <= s2_op_ff;
      s3_r_ff   <= r2;
      s3_z_ff   <= z2;
      s3_ihc_ff <= s2_ihc_ff;
      s3_hhc_ff <= s2_hhc_ff;
      s3_h_ff   <= s2_h_ff;
      s3_d_ff   <= s2_d_ff;
   end

   assign cand_arg = 17'(fx_round(s3_rh_ff)) + 17'(s3_ihc_ff);

   gru_act_rom #(.DEPTH(ACT_TABLE_DEPTH), .IS_TANH(1'b1)) u_rom_cand (
      .clock(clock), .arg(cand_arg), .value_ff(n4)
   );

   always_ff @(posedge clock) begin
      s4_op_ff  <= s3_op_ff;
      s4_r_ff   <= s3_r_ff;
      s4_z_ff   <= s3_z_ff;
      s4_hhc_ff <= s3_hhc_ff;
      s4_h_ff   <= s3_h_ff;
      s4_d_ff   <= s3_d_ff;
   end

   assign omz4 = FX_ONE - s4_z_ff;
   assign omr4 = FX_ONE - s4_r_ff;

   // stage 5: all products that need only gates, n and operands
   always_ff @(posedge clock) begin
      s5_op_ff   <= s4_op_ff;
      s5_zh_ff   <= fx_round(32'(s4_z_ff) * 32'(s4_h_ff));
      s5_omzn_ff <= fx_round(32'(omz4) * 32'(n4));
      s5_c_ff    <= fx_round(32'(omz4) * 32'(s4_d_ff));
      s5_nn_ff   <= fx_round(32'(n4) * 32'(n4));
      s5_zd_ff   <= fx_round(32'(s4_z_ff) * 32'(s4_d_ff));
      s5_rr_ff   <= fx_round(32'(s4_r_ff) * 32'(omr4));
      s5_hmn_ff  <= sat18(18'(s4_h_ff) - 18'(n4));
      s5_r_ff    <= s4_r_ff;
      s5_z_ff    <= s4_z_ff;
      s5_hhc_ff  <= s4_hhc_ff;
   end

   // stage 6
   always_ff @(posedge clock) begin
      s6_op_ff   <= s5_op_ff;
      s6_hnew_ff <= sat18(18'(s5_zh_ff) + 18'(s5_omzn_ff));
      s6_dn_ff   <= sat18(18'(FX_ONE) - 18'(s5_nn_ff));
      s6_c_ff    <= s5_c_ff;
      s6_zhn_ff  <= fx_round(32'(s5_z_ff) * 32'(s5_hmn_ff));
      s6_rrh_ff  <= fx_round(32'(s5_rr_ff) * 32'(s5_hhc_ff));
      s6_zd_ff   <= s5_zd_ff;
      s6_r_ff    <= s5_r_ff;
   end

   // stage 7: candidate gradient and update gradient
   always_ff @(posedge clock) begin
      s7_op_ff   <= s6_op_ff;
      s7_gihc_ff <= fx_round(32'(s6_dn_ff) * 32'(s6_c_ff));
      s7_gupd_ff <= fx_round(32'(s6_zhn_ff) * 32'(s6_c_ff));
      s7_rrh_ff  <= s6_rrh_ff;
      s7_r_ff    <= s6_r_ff;
      s7_hnew_ff <= s6_hnew_ff;
      s7_zd_ff   <= s6_zd_ff;
   end

   // stage 8: last products and field select by opcode
   always_ff @(posedge clock) begin
      case (s7_op_ff)
         OP_FWD: begin
            out_hnew_ff   <= s7_hnew_ff;
            out_greset_ff <= '0;
            out_gupd_ff   <= '0;
            out_gihc_ff   <= '0;
            out_ghhc_ff   <= '0;
            out_ghid_ff   <= '0;
         end
         default: begin
            out_hnew_ff   <= '0;
            out_greset_ff <= fx_round(32'(s7_rrh_ff) * 32'(s7_gihc_ff));
            out_gupd_ff   <= s7_gupd_ff;
            out_gihc_ff   <= s7_gihc_ff;
            out_ghhc_ff   <= fx_round(32'(s7_r_ff) * 32'(s7_gihc_ff));
            out_ghid_ff   <= s7_zd_ff;
         end
      endcase
   end

   assign rsp_valid        = valid_ff[PIPE_LATENCY-1];
   assign rsp_hidden_new   = out_hnew_ff;
   assign rsp_grad_reset   = out_greset_ff;
   assign rsp_grad_update  = out_gupd_ff;
   assign rsp_grad_ih_cand = out_gihc_ff;
   assign rsp_grad_hh_cand = out_ghhc_ff;
   assign rsp_grad_hidden  = out_ghid_ff;
endmodule

@@ design/gru_checker.sv @@
// gru_checker: port-level assertions for gru_gate_fwd_bwd, bound to the top level.
// Depends on gru_pkg for the pipeline latency.
module gru_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            req_opcode,
   input logic                            rsp_valid,
   input logic signed [gru_pkg::FX_W-1:0] rsp_hidden_new,
   input logic signed [gru_pkg::FX_W-1:0] rsp_grad_reset,
   input logic signed [gru_pkg::FX_W-1:0] rsp_grad_update,
   input logic signed [gru_pkg::FX_W-1:0] rsp_grad_ih_cand,
   input logic signed [gru_pkg::FX_W-1:0] rsp_grad_hh_cand,
   input logic signed [gru_pkg::FX_W-1:0] rsp_grad_hidden
);
   import gru_pkg::*;

   // busy only around reset
   a_busy_idle: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !busy)
      else $error("busy high outside reset");

   // each accepted transfer is followed by rsp_valid
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_LATENCY rsp_valid)
      else $error("result missing after transfer");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_LATENCY))
      else $error("result without transfer");

   a_fwd_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_opcode, PIPE_LATENCY) == OP_FWD) |->
      (rsp_grad_reset == 0 && rsp_grad_update == 0 && rsp_grad_ih_cand == 0 &&
       rsp_grad_hh_cand == 0 && rsp_grad_hidden == 0))
      else $error("forward result carries gradients");

   a_bwd_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_opcode, PIPE_LATENCY) == OP_BWD) |-> rsp_hidden_new == 0)
      else $error("backward result carries hidden value");
endmodule

bind gru_gate_fwd_bwd gru_checker u_gru_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .req_opcode(req_opcode),
   .rsp_valid(rsp_valid), .rsp_hidden_new(rsp_hidden_new),
   .rsp_grad_reset(rsp_grad_reset), .rsp_grad_update(rsp_grad_update),
   .rsp_grad_ih_cand(rsp_grad_ih_cand), .rsp_grad_hh_cand(rsp_grad_hh_cand),
   .rsp_grad_hidden(rsp_grad_hidden)
);

@@ tb/tb_top.sv @@
// tb_top: self-checking testbench for gru_gate_fwd_bwd, forward and backward gate math
// depends on gru_pkg (op_type, widths, latency) and the gru_gate_fwd_bwd rtl
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import gru_pkg::*;

   localparam int TBL_DEPTH   = DEF_ACT_TABLE_DEPTH;
   localparam int CYCLE_LIMIT = 400000;
   localparam int NUM_RANDOM  = 750;

   typedef logic signed [FX_W-1:0] fx_type;

   typedef struct {
      op_type opcode;
      fx_type ih_reset, ih_update, ih_cand;
      fx_type hh_reset, hh_update, hh_cand;
      fx_type hidden_old, grad_in;
   } gate_req_type;

   typedef struct {
      fx_type hidden_new, grad_reset, grad_update;
      fx_type grad_ih_cand, grad_hh_cand, grad_hidden;
   } gate_rsp_type;

   // golden gate math plus the queue of results still owed by the pipeline
   class gate_scoreboard;
      fx_type       sig_tbl[TBL_DEPTH];
      fx_type       tanh_tbl[TBL_DEPTH];
      gate_rsp_type pending[$];
      int           errors;

      function new();
         longint k;
         longint unsigned mag, arg, ex, den;
         errors = 0;
         for (int i = 0; i < TBL_DEPTH; i++) begin
            k   = 2 * longint'(i) + 1 - TBL_DEPTH;
            mag = (k < 0) ? -k : k;
            // sigmoid at the bin midpoint
            arg = ((mag << 33) + TBL_DEPTH / 2) / TBL_DEPTH;
            ex  = exp_neg(arg);
            den = (64'd1 << 30) + ex;
            if (k < 0) sig_tbl[i] = fx_type'(((ex << 11) + den / 2) / den);
            else       sig_tbl[i] = fx_type'(((64'd1 << 41) + den / 2) / den);
            // tanh via e^-2a
            arg = ((mag << 34) + TBL_DEPTH / 2) / TBL_DEPTH;
            ex  = exp_neg(arg);
            den = (64'd1 << 30) + ex;
            tanh_tbl[i] = fx_type'(((((64'd1 << 30) - ex) << 11) + den / 2) / den);
            if (k < 0) tanh_tbl[i] = -tanh_tbl[i];
         end
      endfunction

      // e^-a in q30: e^-1 per integer unit, truncated taylor for the fraction
      function longint unsigned exp_neg(longint unsigned a);
         longint unsigned whole, frac, term, res;
         longint acc;
         whole = a >> 30;
         frac  = a & ((64'd1 << 30) - 1);
         acc   = longint'(64'd1 << 30);
         term  = 64'd1 << 30;
         for (int j = 1; j <= 20; j++) begin
            term = ((term * frac) >> 30) / j;
            if (j % 2 == 1) acc -= longint'(term);
            else            acc += longint'(term);
         end
         if (acc < 0) acc = 0;
         res = acc;
         for (longint unsigned j = 0; j < whole && j < 64; j++)
            res = (res * 64'd395007542 + (64'd1 << 29)) >> 30;
         return res;
      endfunction

      function int clip16(longint v);
         if (v > 32767) return 32767;
         if (v < -32768) return -32768;
         return int'(v);
      endfunction

      // q4.11 product, round half up, saturate
      function int qmul(int a, int b);
         longint s;
         s = longint'(a) * longint'(b) + 1024;
         return clip16(s >>> 11);
      endfunction

      function int tbl_index(longint x);
         if (x < -16384) x = -16384;
         if (x > 16383) x = 16383;
         return int'(((x + 16384) * TBL_DEPTH) >>> 15);
      endfunction

      function gate_rsp_type predict(gate_req_type q);
         gate_rsp_type o;
         int r, z, n, omz, c, dn, gihc, rr;
         r   = sig_tbl[tbl_index(longint'(q.ih_reset) + q.hh_reset)];
         z   = sig_tbl[tbl_index(longint'(q.ih_update) + q.hh_update)];
         n   = tanh_tbl[tbl_index(longint'(qmul(r, q.hh_cand)) + q.ih_cand)];
         omz = 2048 - z;
         o   = '{default: '0};
         if (q.opcode == OP_FWD) begin
            o.hidden_new = fx_type'(clip16(longint'(qmul(z, q.hidden_old)) + qmul(omz, n)));
         end else begin
            c    = qmul(omz, q.grad_in);
            dn   = clip16(2048 - longint'(qmul(n, n)));
            gihc = qmul(dn, c);
            rr   = qmul(r, 2048 - r);
            o.grad_reset   = fx_type'(qmul(qmul(rr, q.hh_cand), gihc));
            o.grad_update  = fx_type'(qmul(qmul(z, clip16(longint'(q.hidden_old) - n)), c));
            o.grad_ih_cand = fx_type'(gihc);
            o.grad_hh_cand = fx_type'(qmul(r, gihc));
            o.grad_hidden  = fx_type'(qmul(z, q.grad_in));
         end
         return o;
      endfunction

      function void note_transfer(gate_req_type q);
         pending.push_back(predict(q));
      endfunction

      function void cmp(string name, fx_type exp_v, fx_type act_v);
         if (exp_v !== act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_result(gate_rsp_type got);
         gate_rsp_type want;
         if (pending.size() == 0) begin
            $error("result with nothing outstanding");
            errors++;
            return;
         end
         want = pending.pop_front();
         cmp("hidden_new", want.hidden_new, got.hidden_new);
         cmp("grad_reset", want.grad_reset, got.grad_reset);
         cmp("grad_update", want.grad_update, got.grad_update);
         cmp("grad_ih_cand", want.grad_ih_cand, got.grad_ih_cand);
         cmp("grad_hh_cand", want.grad_hh_cand, got.grad_hh_cand);
         cmp("grad_hidden", want.grad_hidden, got.grad_hidden);
      endfunction
   endclass

   logic   clock, reset, start, busy, rsp_valid;
   logic   req_opcode;
   fx_type req_ih_reset, req_ih_update, req_ih_cand;
   fx_type req_hh_reset, req_hh_update, req_hh_cand;
   fx_type req_hidden_old, req_grad_in;
   fx_type rsp_hidden_new, rsp_grad_reset, rsp_grad_update;
   fx_type rsp_grad_ih_cand, rsp_grad_hh_cand, rsp_grad_hidden;

   gate_scoreboard sb;

   // values seen at mid-cycle stand for what the next rising edge samples
   logic         busy_s, valid_s;
   gate_rsp_type rsp_s;
   int           cycles = 0;

   gru_gate_fwd_bwd uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode),
      .req_ih_reset(req_ih_reset), .req_ih_update(req_ih_update),
      .req_ih_cand(req_ih_cand), .req_hh_reset(req_hh_reset),
      .req_hh_update(req_hh_update), .req_hh_cand(req_hh_cand),
      .req_hidden_old(req_hidden_old), .req_grad_in(req_grad_in),
      .rsp_valid(rsp_valid),
      .rsp_hidden_new(rsp_hidden_new), .rsp_grad_reset(rsp_grad_reset),
      .rsp_grad_update(rsp_grad_update), .rsp_grad_ih_cand(rsp_grad_ih_cand),
      .rsp_grad_hh_cand(rsp_grad_hh_cand), .rsp_grad_hidden(rsp_grad_hidden)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      busy_s  <= busy;
      valid_s <= rsp_valid;
      rsp_s   <= '{rsp_hidden_new, rsp_grad_reset, rsp_grad_update,
                   rsp_grad_ih_cand, rsp_grad_hh_cand, rsp_grad_hidden};
   end

   // result side: every strobe is one transfer, no back pressure possible
   always @(posedge clock) begin
      if (!reset && valid_s === 1'b1) sb.check_result(rsp_s);
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("gru_gate_fwd_bwd verification failed");
         $finish;
      end
   end

   // one operand: mostly inside the table span so gates take interior values,
   // sometimes anywhere in the 16-bit range to hit clamping and saturation
   function automatic fx_type rand_operand();
      case ($urandom_range(0, 9))
         0, 1, 2:   return fx_type'($urandom);
         3:         return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         default:   return fx_type'(int'($urandom_range(0, 16383)) - 8192);
      endcase
   endfunction

   function automatic gate_req_type rand_req();
      gate_req_type q;
      q.opcode     = $urandom_range(0, 1) ? OP_BWD : OP_FWD;
      q.ih_reset   = rand_operand();
      q.ih_update  = rand_operand();
      q.ih_cand    = rand_operand();
      q.hh_reset   = rand_operand();
      q.hh_update  = rand_operand();
      q.hh_cand    = rand_operand();
      q.hidden_old = rand_operand();
      q.grad_in    = rand_operand();
      return q;
   endfunction

   // idle gap, then hold start until the block takes the transfer
   task automatic send(gate_req_type q, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_opcode     <= q.opcode;
      req_ih_reset   <= q.ih_reset;
      req_ih_update  <= q.ih_update;
      req_ih_cand    <= q.ih_cand;
      req_hh_reset   <= q.hh_reset;
      req_hh_update  <= q.hh_update;
      req_hh_cand    <= q.hh_cand;
      req_hidden_old <= q.hidden_old;
      req_grad_in    <= q.grad_in;
      do @(posedge clock); while (busy_s !== 1'b0);
      sb.note_transfer(q);
   endtask

   // random gap 0..14, with bursts of back-to-back transfers now and then
   function automatic int draw_gap(bit burst);
      return burst ? 0 : $urandom_range(0, 14);
   endfunction

   initial begin
      gate_req_type q;
      fx_type       ext[4];
      bit           burst;
      int           waited;
      sb = new();
      busy_s = 1'b1;
      valid_s = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_opcode = OP_FWD;
      {req_ih_reset, req_ih_update, req_ih_cand, req_hh_reset} = '0;
      {req_hh_update, req_hh_cand, req_hidden_old, req_grad_in} = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: zeros, extremes, clamped table inputs, saturating products
      ext = '{16'sh0000, 16'sh7fff, 16'sh8000, 16'sh0800};
      for (int i = 0; i < 4; i++) begin
         for (int op = 0; op < 2; op++) begin
            q = '{op ? OP_BWD : OP_FWD, ext[i], ext[i], ext[i], ext[i],
                  ext[i], ext[i], ext[i], ext[i]};
            send(q, op);
         end
      end
      // pre-activations just beyond the table ends, max hidden and gradient
      q = '{OP_BWD, 16'sh2000, 16'sh2001, -16'sh4000, 16'sh2000,
            16'sh2000, 16'sh7fff, 16'sh7fff, 16'sh8000};
      send(q, 0);
      q = '{OP_BWD, -16'sh2000, -16'sh2001, 16'sh3fff, -16'sh2000,
            -16'sh2000, 16'sh8000, 16'sh8000, 16'sh7fff};
      send(q, 2);
      q = '{OP_FWD, 16'sh2000, 16'sh2001, -16'sh4000, 16'sh2000,
            16'sh2000, 16'sh7fff, 16'sh7fff, 16'sh8000};
      send(q, 0);
      // gates at one half, large opposite-signed hidden and candidate
      q = '{OP_BWD, 16'sh0000, 16'sh0000, 16'sh1000, 16'sh0000,
            16'sh0000, 16'sh7fff, 16'sh8000, 16'sh7fff};
      send(q, 1);
      q = '{OP_FWD, 16'sh0000, 16'sh0000, -16'sh1000, 16'sh0000,
            16'sh0000, 16'sh8000, 16'sh7fff, 16'sh0001};
      send(q, 0);
      // opposite signs that cancel in the pre-activation sum
      q = '{OP_BWD, 16'sh7fff, 16'sh8000, 16'sh0400, 16'sh8001,
            16'sh7fff, 16'sh0400, 16'sh0400, 16'sh0400};
      send(q, 3);

      // random part, with stretches of no idling
      burst = 1'b0;
      for (int i = 0; i < NUM_RANDOM; i++) begin
         if ($urandom_range(0, 19) == 0) burst = ~burst;
         send(rand_req(), draw_gap(burst));
      end
      start <= 1'b0;

      // drain the pipeline
      waited = 0;
      while (sb.pending.size() != 0 && waited < 100 * PIPE_LATENCY) begin
         @(posedge clock);
         waited++;
      end
      repeat (PIPE_LATENCY + 4) @(posedge clock);
      if (sb.pending.size() != 0) begin
         $error("%0d results never arrived", sb.pending.size());
         sb.errors++;
      end

      if (sb.errors == 0) begin
         $display("gru_gate_fwd_bwd verification clean");
      end else begin
         $display("gru_gate_fwd_bwd verification failed");
      end
      $finish;
   end

endmodule

@@ gru_gate_fwd_bwd.f @@
design/gru_pkg.sv
design/gru_act_rom.sv
design/gru_gate_fwd_bwd.sv
design/gru_checker.sv
tb/tb_top.sv
